[hw/rtl/u2c_pkg.sv]
package u2c_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_UNKNOWN_CHAR = 1'd1;

	localparam logic [15:0] CAPACITY_RST = 16'd256;
	localparam logic [7:0] UNKNOWN_CHAR_RST = 8'd42;

	typedef struct packed {
		logic [7:0] in_byte;
		logic in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic out_last;
		logic dropped;
	} out_item_t;

	// results of one input byte: up to three equal characters, then maybe a terminator
	typedef struct packed {
		logic [7:0] chr;
		logic [1:0] chars;
		logic term;
		logic drop;
	} grp_t;

endpackage

[hw/rtl/utf8_to_cp1251_stream_top.sv]
// UTF-8 to CP1251 byte stream converter. One input byte is accepted per cycle whenever the
// result register is free or its last result leaves in the same cycle; each byte gives
// zero to four results (three for an ellipsis, plus a terminating zero), sent one per
// cycle while out_stall is low, so a byte with several results stalls the input until its
// last result leaves, and a byte with none (a lead byte) leaves the input free. Every
// message ends with a zero byte marked out_last whose dropped bit tells whether
// characters beyond capacity minus one were lost. capacity and unknown_char are written
// by index 0 and 1 and should only change while no message is being converted.
module utf8_to_cp1251_stream_top #(
	parameter int COUNT_WIDTH = u2c_pkg::COUNT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input u2c_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output u2c_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [u2c_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [u2c_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [15:0] capacity_q;
	logic [7:0] unknown_char_q;
	u2c_pkg::grp_t grp;
	logic grp_valid_s1;
	logic [7:0] chr_s1;
	logic [1:0] chars_s1;
	logic term_s1;
	logic drop_s1;
	logic in_accept;
	logic out_take;
	logic grp_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= u2c_pkg::CAPACITY_RST;
			unknown_char_q <= u2c_pkg::UNKNOWN_CHAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				u2c_pkg::REG_CAPACITY: capacity_q <= cfg_data[15:0];
				u2c_pkg::REG_UNKNOWN_CHAR: unknown_char_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	u2c_decode #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_accept),
		.item(in_data),
		.capacity(capacity_q),
		.unknown_char(unknown_char_q),
		.grp(grp)
	);

	assign out_take = grp_valid_s1 && !out_stall;
	// last result of the group leaves this cycle
	assign grp_done = out_take && ((chars_s1 == 2'd1 && !term_s1) || chars_s1 == 2'd0);
	assign in_stall = grp_valid_s1 && !grp_done;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_s1 <= 1'b0;
			chars_s1 <= 2'd0;
			term_s1 <= 1'b0;
		end else if (in_accept) begin
			grp_valid_s1 <= (grp.chars != 2'd0) || grp.term;
			chars_s1 <= grp.chars;
			term_s1 <= grp.term;
		end else if (grp_done) begin
			grp_valid_s1 <= 1'b0;
		end else if (out_take && chars_s1 != 2'd0) begin
			chars_s1 <= chars_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			chr_s1 <= grp.chr;
			drop_s1 <= grp.drop;
		end
	end

	assign out_valid = grp_valid_s1;
	assign out_data.out_byte = (chars_s1 != 2'd0) ? chr_s1 : 8'h00;
	assign out_data.out_last = (chars_s1 == 2'd0);
	assign out_data.dropped = (chars_s1 == 2'd0) && drop_s1;

`ifndef SYNTHESIS
	a_group_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid_s1 |-> (chars_s1 != 2'd0 || term_s1))
		else $error("empty result group held");

	a_no_accept_mid_group: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (!grp_valid_s1 || grp_done))
		else $error("input taken while results still pending");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.out_last) |-> (out_data.out_byte == 8'h00))
		else $error("terminator byte not zero");

	a_drop_on_term: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.out_last) |-> !out_data.dropped)
		else $error("dropped flag on a character");

	a_chars_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && !grp_done && chars_s1 != 2'd0) |=> (chars_s1 == $past(chars_s1) - 2'd1))
		else $error("character count did not step");
`endif

endmodule

[hw/rtl/u2c_decode.sv]
module u2c_decode #(
	parameter int COUNT_WIDTH = u2c_pkg::COUNT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input u2c_pkg::in_item_t item,
	input logic [15:0] capacity,
	input logic [7:0] unknown_char,
	output u2c_pkg::grp_t grp
);

	localparam int LW = COUNT_WIDTH + 17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_D0,
		ST_D1,
		ST_C2,
		ST_OTHER,
		ST_E2_A,
		ST_E2_80,
		ST_E2_X
	} lead_t;

	lead_t lead_q;
	lead_t lead_nxt;
	logic [COUNT_WIDTH-1:0] wc_q;
	logic ovf_q;

	logic [7:0] c;
	logic [7:0] chr;
	logic [1:0] want;
	logic finish;
	logic [15:0] cap_m1;
	logic [LW-1:0] limit;
	logic [LW-1:0] cmax;
	logic [LW-1:0] wc_ext;
	logic [LW-1:0] room;
	logic [1:0] n;
	logic ovf_nxt;

	assign c = item.in_byte;

	always_comb begin
		lead_nxt = ST_IDLE;
		chr = unknown_char;
		want = 2'd0;
		finish = item.in_last;
		case (lead_q)
			ST_D0: begin
				want = 2'd1;
				if (c >= 8'h90 && c < 8'hD0) begin
					chr = c + 8'h30;
				end else if (c == 8'h81) begin
					chr = 8'hA8;
				end else begin
					chr = c;
				end
			end
			ST_D1: begin
				want = 2'd1;
				if (c >= 8'h80 && c < 8'h90) begin
					chr = c + 8'h70;
				end else if (c == 8'h91) begin
					chr = 8'hB8;
				end else begin
					chr = c;
				end
			end
			ST_C2: begin
				want = 2'd1;
				chr = (c == 8'hAB || c == 8'hBB) ? 8'h22 : unknown_char;
			end
			ST_OTHER, ST_E2_X: begin
				want = 2'd1;
			end
			ST_E2_A: begin
				lead_nxt = (c == 8'h80) ? ST_E2_80 : ST_E2_X;
				// message ends inside the triple: one unknown character
				if (item.in_last) begin
					want = 2'd1;
				end
			end
			ST_E2_80: begin
				if (c == 8'h94) begin
					chr = 8'h2D;
					want = 2'd2;
				end else if (c == 8'hA6) begin
					chr = 8'h2E;
					want = 2'd3;
				end else begin
					want = 2'd1;
				end
			end
			default: begin
				if (c == 8'h00) begin
					finish = 1'b1;
				end else if (c < 8'h80) begin
					chr = c;
					want = 2'd1;
				end else if (c == 8'hD0) begin
					lead_nxt = ST_D0;
				end else if (c == 8'hD1) begin
					lead_nxt = ST_D1;
				end else if (c == 8'hC2) begin
					lead_nxt = ST_C2;
				end else if (c == 8'hE2) begin
					lead_nxt = ST_E2_A;
				end else begin
					lead_nxt = ST_OTHER;
				end
			end
		endcase
	end

	// room left in the message, clamped to what the counter holds
	always_comb begin
		cap_m1 = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
		cmax = LW'({COUNT_WIDTH{1'b1}});
		limit = LW'(cap_m1);
		if (limit > cmax) begin
			limit = cmax;
		end
		wc_ext = LW'(wc_q);
		room = (limit > wc_ext) ? limit - wc_ext : '0;
		n = (room >= LW'(want)) ? want : room[1:0];
		ovf_nxt = ovf_q | (n != want);
	end

	assign grp.chr = chr;
	assign grp.chars = n;
	assign grp.term = finish;
	assign grp.drop = ovf_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= ST_IDLE;
			wc_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (finish) begin
				lead_q <= ST_IDLE;
				wc_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				lead_q <= lead_nxt;
				wc_q <= wc_q + COUNT_WIDTH'(n);
				ovf_q <= ovf_nxt;
			end
		end
	end

endmodule

[sim/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 300;

	localparam logic [7:0] B_D0 = 8'hD0;
	localparam logic [7:0] B_D1 = 8'hD1;
	localparam logic [7:0] B_C2 = 8'hC2;
	localparam logic [7:0] B_E2 = 8'hE2;
	localparam logic [7:0] UNK_RST = u2c_pkg::UNKNOWN_CHAR_RST;

	typedef enum logic [2:0] {
		L_IDLE, L_D0, L_D1, L_C2, L_OTHER, L_E2, L_E2_80, L_E2_X
	} lead_t;

	// how a directed row is checked: by the converter model or by typed results
	typedef enum logic [2:0] {R_PRED, R_NONE, R_CHR, R_TERM, R_CHR_TERM} row_kind_t;

	typedef struct packed {
		u2c_pkg::in_item_t it;
		row_kind_t kind;
		logic [7:0] chr;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	u2c_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	u2c_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [u2c_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [u2c_pkg::CFG_DATA_W-1:0] cfg_data;

	// converter model state and register copies
	lead_t lead_st;
	logic [u2c_pkg::COUNT_WIDTH_DEF-1:0] wr_cnt;
	logic ovf;
	logic [15:0] cap_reg;
	logic [7:0] unk_reg;

	u2c_pkg::out_item_t step_q[$];
	u2c_pkg::out_item_t cp1251_q[$];
	u2c_pkg::in_item_t msg_q[$];
	row_t dir_tab[$];

	bit quiet;
	bit hold_req;
	int hold_left;
	int cycles;
	int errs;
	int n_in, n_out, n_msgs, n_drops, n_cfg;

	utf8_to_cp1251_stream_top i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.in_data,
		.out_valid,
		.out_stall,
		.out_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("utf8_to_cp1251_stream_top verification failed");
			$finish;
		end
	end

	// receiver: random stalls, quiet stretches and one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 35);
		end
	end

	always @(posedge clk) begin
		u2c_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cp1251_q.size() == 0) begin
				$error("unexpected transaction: out_byte %h out_last %b dropped %b",
					out_data.out_byte, out_data.out_last, out_data.dropped);
				errs++;
			end else begin
				want = cp1251_q.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
					errs++;
				end
				if (out_data.out_last !== want.out_last) begin
					$error("out_last: expected %b, got %b", want.out_last, out_data.out_last);
					errs++;
				end
				if (out_data.dropped !== want.dropped) begin
					$error("dropped: expected %b, got %b", want.dropped, out_data.dropped);
					errs++;
				end
			end
			n_out++;
			if (out_data.out_last) n_msgs++;
			if (out_data.out_last && out_data.dropped) n_drops++;
		end
	end

	function automatic void add_chr(input logic [7:0] b);
		logic [15:0] room;
		room = (cap_reg == 16'd0) ? 16'd0 : cap_reg - 16'd1;
		if (wr_cnt < room) begin
			step_q.push_back('{out_byte: b, out_last: 1'b0, dropped: 1'b0});
			wr_cnt = wr_cnt + 1'b1;
		end else begin
			ovf = 1'b1;
		end
	endfunction

	function automatic void convert_byte(input u2c_pkg::in_item_t it);
		logic [7:0] c;
		bit fin;
		c = it.in_byte;
		fin = it.in_last;
		step_q.delete();
		case (lead_st)
			L_D0: begin
				lead_st = L_IDLE;
				if (c >= 8'h90 && c < 8'hD0) add_chr(c + 8'h30);
				else if (c == 8'h81) add_chr(8'hA8);
				else add_chr(c);
			end
			L_D1: begin
				lead_st = L_IDLE;
				if (c >= 8'h80 && c < 8'h90) add_chr(c + 8'h70);
				else if (c == 8'h91) add_chr(8'hB8);
				else add_chr(c);
			end
			L_C2: begin
				lead_st = L_IDLE;
				add_chr((c == 8'hAB || c == 8'hBB) ? 8'h22 : unk_reg);
			end
			L_OTHER, L_E2_X: begin
				lead_st = L_IDLE;
				add_chr(unk_reg);
			end
			L_E2: lead_st = (c == 8'h80) ? L_E2_80 : L_E2_X;
			L_E2_80: begin
				lead_st = L_IDLE;
				if (c == 8'h94) begin
					add_chr(8'h2D);
					add_chr(8'h2D);
				end else if (c == 8'hA6) begin
					add_chr(8'h2E);
					add_chr(8'h2E);
					add_chr(8'h2E);
				end else begin
					add_chr(unk_reg);
				end
			end
			default: begin
				if (c == 8'h00) fin = 1'b1;
				else if (c < 8'h80) add_chr(c);
				else if (c == B_D0) lead_st = L_D0;
				else if (c == B_D1) lead_st = L_D1;
				else if (c == B_C2) lead_st = L_C2;
				else if (c == B_E2) lead_st = L_E2;
				else lead_st = L_OTHER;
			end
		endcase
		if (fin) begin
			// message cut after the second byte of a three-byte sequence
			if (lead_st == L_E2_80 || lead_st == L_E2_X) add_chr(unk_reg);
			step_q.push_back('{out_byte: 8'h00, out_last: 1'b1, dropped: ovf});
			lead_st = L_IDLE;
			wr_cnt = '0;
			ovf = 1'b0;
		end
	endfunction

	function automatic row_t dir_row(input logic [7:0] b, input logic l, input row_kind_t k,
			input logic [7:0] chr = 8'h00);
		return '{it: '{in_byte: b, in_last: l}, kind: k, chr: chr};
	endfunction

	function automatic void add_in(input logic [7:0] b);
		msg_q.push_back('{in_byte: b, in_last: 1'b0});
	endfunction

	// one message of mostly well-formed characters, with some noise
	function automatic void build_msg(input int maxp);
		int pieces;
		int sel;
		bit noisy;
		u2c_pkg::in_item_t tail;
		msg_q.delete();
		noisy = 1'b0;
		pieces = $urandom_range(maxp, 1);
		repeat (pieces) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				add_in(8'($urandom_range(127, 1)));
			end else if (sel < 48) begin
				add_in(B_D0);
				add_in(($urandom_range(7) == 0) ? 8'h81 : 8'($urandom_range(8'hCF, 8'h80)));
			end else if (sel < 63) begin
				add_in(B_D1);
				add_in(($urandom_range(7) == 0) ? 8'h91 : 8'($urandom_range(8'hBF, 8'h80)));
			end else if (sel < 70) begin
				add_in(B_C2);
				if ($urandom_range(1)) add_in($urandom_range(1) ? 8'hAB : 8'hBB);
				else add_in(8'($urandom));
			end else if (sel < 82) begin
				add_in(B_E2);
				if ($urandom_range(3) == 0) begin
					add_in(8'($urandom));
					add_in(8'($urandom));
				end else begin
					add_in(8'h80);
					sel = $urandom_range(2);
					add_in(sel == 0 ? 8'h94 : sel == 1 ? 8'hA6 : 8'($urandom));
				end
			end else if (sel < 92) begin
				add_in(8'($urandom_range(8'hFF, 8'h80)));
				add_in(8'($urandom));
				noisy = 1'b1;
			end else begin
				add_in(8'($urandom));
				noisy = 1'b1;
			end
		end
		if (!noisy && $urandom_range(1)) begin
			msg_q.push_back('{in_byte: 8'h00, in_last: 1'($urandom_range(1))});
		end else begin
			tail = msg_q.pop_back();
			tail.in_last = 1'b1;
			msg_q.push_back(tail);
		end
	endfunction

	task automatic send_byte(input u2c_pkg::in_item_t it, input bit keep);
		int gap;
		gap = (!quiet && $urandom_range(99) < 35) ? int'($urandom_range(2, 1)) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		convert_byte(it);
		n_in++;
		if (keep) foreach (step_q[k]) cp1251_q.push_back(step_q[k]);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (cp1251_q.size() != 0) @(posedge clk);
		// a lead byte may still sit in the block with no result pending
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] cap, input logic [7:0] unk);
		cfg_valid <= 1'b1;
		cfg_index <= u2c_pkg::REG_CAPACITY;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = cap;
		cfg_index <= u2c_pkg::REG_UNKNOWN_CHAR;
		cfg_data <= {8'($urandom), unk};
		do @(posedge clk); while (!cfg_ready);
		unk_reg = unk;
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	initial begin
		int ph, sent, n_m, budget, maxp;
		logic [15:0] cap;
		logic [7:0] unk;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		cycles = 0;
		errs = 0;
		lead_st = L_IDLE;
		wr_cnt = '0;
		ovf = 1'b0;
		cap_reg = u2c_pkg::CAPACITY_RST;
		unk_reg = u2c_pkg::UNKNOWN_CHAR_RST;

		// directed rows run on the reset values of the registers
		dir_tab.push_back(dir_row(8'h41, 1'b0, R_CHR, 8'h41));
		dir_tab.push_back(dir_row(8'h7F, 1'b0, R_CHR, 8'h7F));
		dir_tab.push_back(dir_row(B_D0, 1'b0, R_NONE));
		dir_tab.push_back(dir_row(8'h90, 1'b0, R_CHR, 8'hC0));
		dir_tab.push_back(dir_row(B_D0, 1'b0, R_NONE));
		dir_tab.push_back(dir_row(8'h81, 1'b0, R_CHR, 8'hA8));
		dir_tab.push_back(dir_row(B_D1, 1'b0, R_NONE));
		dir_tab.push_back(dir_row(8'h8F, 1'b0, R_CHR, 8'hFF));
		dir_tab.push_back(dir_row(B_D1, 1'b0, R_NONE));
		dir_tab.push_back(dir_row(8'h91, 1'b0, R_CHR, 8'hB8));
		dir_tab.push_back(dir_row(B_C2, 1'b0, R_NONE));
		dir_tab.push_back(dir_row(8'hBB, 1'b0, R_CHR, 8'h22));
		dir_tab.push_back(dir_row(B_E2, 1'b0, R_PRED));
		dir_tab.push_back(dir_row(8'h80, 1'b0, R_PRED));
		dir_tab.push_back(dir_row(8'hA6, 1'b0, R_PRED));
		dir_tab.push_back(dir_row(B_E2, 1'b0, R_PRED));
		dir_tab.push_back(dir_row(8'h80, 1'b0, R_PRED));
		dir_tab.push_back(dir_row(8'h94, 1'b0, R_PRED));
		// zero after a lead byte is a continuation, not an end of message
		dir_tab.push_back(dir_row(8'hFF, 1'b0, R_NONE));
		dir_tab.push_back(dir_row(8'h00, 1'b0, R_CHR, UNK_RST));
		dir_tab.push_back(dir_row(B_D0, 1'b0, R_NONE));
		dir_tab.push_back(dir_row(8'h00, 1'b0, R_CHR, 8'h00));
		dir_tab.push_back(dir_row(8'h00, 1'b0, R_TERM));
		// truncated sequences at the end of a message
		dir_tab.push_back(dir_row(B_E2, 1'b0, R_NONE));
		dir_tab.push_back(dir_row(8'h81, 1'b1, R_CHR_TERM, UNK_RST));
		dir_tab.push_back(dir_row(B_D0, 1'b1, R_TERM));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[k]) begin
			send_byte(dir_tab[k].it, dir_tab[k].kind == R_PRED);
			if (dir_tab[k].kind == R_CHR || dir_tab[k].kind == R_CHR_TERM)
				cp1251_q.push_back('{out_byte: dir_tab[k].chr, out_last: 1'b0, dropped: 1'b0});
			if (dir_tab[k].kind == R_TERM || dir_tab[k].kind == R_CHR_TERM)
				cp1251_q.push_back('{out_byte: 8'h00, out_last: 1'b1, dropped: 1'b0});
		end

		for (ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					cap = u2c_pkg::CAPACITY_RST;
					unk = u2c_pkg::UNKNOWN_CHAR_RST;
					budget = 60;
					maxp = 12;
				end
				1: begin cap = 16'd1; unk = 8'h00; budget = 60; maxp = 6; end
				2: begin cap = 16'd0; unk = 8'hFF; budget = 40; maxp = 6; end
				3: begin cap = 16'hFFFF; unk = 8'h3F; budget = 90; maxp = 16; end
				4: begin
					cap = 16'($urandom_range(12, 2));
					unk = 8'($urandom);
					budget = 100;
					maxp = 10;
				end
				5: begin
					cap = 16'($urandom_range(64, 13));
					unk = 8'($urandom);
					budget = 70;
					maxp = 20;
				end
				default: begin cap = 16'd2; unk = 8'h80; budget = 40; maxp = 5; end
			endcase
			if (ph != 0) set_config(cap, unk);
			quiet = (ph == 3);
			// long hold-off while bytes keep coming, so the input backs up
			if (ph == 0 || ph == 5) hold_req = 1'b1;
			sent = 0;
			n_m = 0;
			while (sent < budget) begin
				build_msg(maxp);
				foreach (msg_q[k]) send_byte(msg_q[k], 1'b1);
				sent += msg_q.size();
				n_m++;
				if (ph == 4 && n_m % 5 == 0) wait_idle();
			end
			wait_idle();
		end

		$display("converted %0d bytes into %0d results over %0d messages (%0d with drops)",
			n_in, n_out, n_msgs, n_drops);
		$display("%0d register settings, capacity from 0 to 65535", n_cfg + 1);
		if (errs == 0)
			$display("utf8_to_cp1251_stream_top verification clean");
		else
			$display("utf8_to_cp1251_stream_top verification failed");
		$finish;
	end

endmodule
